### rtl/dark_key_stamp_blit_core_macros.svh
// ----------------------------------------------------------------------------
// dark_key_stamp_blit_core_macros
// assertion macros shared by the stamp blit modules
// ----------------------------------------------------------------------------
`ifndef DARK_KEY_STAMP_BLIT_CORE_MACROS_SVH
`define DARK_KEY_STAMP_BLIT_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define DKSB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DKSB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/dksb_pkg.sv
// ----------------------------------------------------------------------------
// dksb_pkg
// types, constants and per-axis clip arithmetic for the stamp blit
// ----------------------------------------------------------------------------
package dksb_pkg;

    localparam int DIM_W   = 13;
    localparam int CNT_W   = 12;
    localparam int COORD_W = 14;
    localparam int OFS_W   = 15;
    localparam int POS_W   = 16;
    localparam int IDX_W   = 4;
    localparam int CDATA_W = 13;
    localparam int SUM_W   = 10;

    localparam logic [DIM_W-1:0] MAX_DIM        = 13'd4096;
    localparam logic [SUM_W-1:0] DARK_SUM_LIMIT = 10'd96;

    typedef enum logic [IDX_W-1:0] {
        REG_DEST_WIDTH   = 4'd0,
        REG_DEST_HEIGHT  = 4'd1,
        REG_BRUSH_WIDTH  = 4'd2,
        REG_BRUSH_HEIGHT = 4'd3,
        REG_STAMP_RED    = 4'd4,
        REG_STAMP_GREEN  = 4'd5,
        REG_STAMP_BLUE   = 4'd6,
        REG_STAMP_ALPHA  = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] dest_width;
        logic [DIM_W-1:0] dest_height;
        logic [DIM_W-1:0] brush_width;
        logic [DIM_W-1:0] brush_height;
        logic [7:0]       stamp_red;
        logic [7:0]       stamp_green;
        logic [7:0]       stamp_blue;
        logic [7:0]       stamp_alpha;
    } dksb_cfg_t;

    typedef struct packed {
        logic                    ok;
        logic signed [OFS_W-1:0] ofs;
        logic [DIM_W-1:0]        lim;
    } dksb_axis_t;

    typedef struct packed {
        logic                    hit;
        logic [CNT_W-1:0]        col;
        logic [CNT_W-1:0]        row;
        logic signed [OFS_W-1:0] ofs_x;
        logic signed [OFS_W-1:0] ofs_y;
        logic [DIM_W-1:0]        lim_x;
        logic [DIM_W-1:0]        lim_y;
    } dksb_item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    // window test and start offset for one axis in doubled coordinates
    function automatic dksb_axis_t axis_setup(
        input logic signed [COORD_W-1:0] c,
        input logic [DIM_W-1:0]          b,
        input logic [DIM_W-1:0]          d,
        input logic [CNT_W-1:0]          k
    );
        logic signed [16:0] c2;
        logic signed [16:0] bs;
        logic signed [16:0] ds2;
        logic signed [16:0] s;
        logic signed [16:0] e2;
        logic signed [16:0] half;
        logic signed [16:0] neg_s;
        logic signed [16:0] lim;
        dksb_axis_t         r;
        c2    = $signed({{2{c[COORD_W-1]}}, c, 1'b0});
        bs    = $signed({4'b0, b});
        ds2   = $signed({3'b0, d, 1'b0});
        s     = c2 - bs;
        e2    = c2 + bs;
        neg_s = -s;
        half  = s[16] ? -(neg_s >>> 1) : (s >>> 1);
        lim   = (e2 < ds2) ? (e2 >>> 1) : $signed({4'b0, d});
        r.ok  = (-bs < c2) && (c2 < ds2 + bs) && ({1'b0, k} < b);
        r.ofs = half[OFS_W-1:0];
        r.lim = lim[DIM_W-1:0];
        return r;
    endfunction

endpackage

### rtl/dksb_if.sv
// ----------------------------------------------------------------------------
// dksb_if
// valid/ready channels of the stamp blit: brush pixels, writes, config
// ----------------------------------------------------------------------------
interface dksb_in_if;
    import dksb_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      new_stamp;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [7:0]                pixel_red;
    logic [7:0]                pixel_green;
    logic [7:0]                pixel_blue;

    modport source (
        output valid, new_stamp, center_x, center_y, pixel_red, pixel_green, pixel_blue,
        input  ready
    );
    modport sink (
        input  valid, new_stamp, center_x, center_y, pixel_red, pixel_green, pixel_blue,
        output ready
    );
endinterface

interface dksb_out_if;
    import dksb_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] write_x;
    logic [CNT_W-1:0] write_y;
    logic [31:0]      write_color;

    modport source (output valid, write_x, write_y, write_color, input ready);
    modport sink (input valid, write_x, write_y, write_color, output ready);
endinterface

interface dksb_cfg_if;
    import dksb_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/dksb_front.sv
// ----------------------------------------------------------------------------
// dksb_front
// accepts brush pixels, tracks brush column and row, classifies each item
// ----------------------------------------------------------------------------
module dksb_front
    import dksb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dksb_in_if.sink       brush,
    input  dksb_cfg_t     cfg,
    input  logic          full,
    output logic          push,
    output dksb_item_t    item
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col, row;
    logic [DIM_W-1:0] bw, bh, dw, dh;
    logic [SUM_W-1:0] sum;
    logic [DIM_W-1:0] col_inc;
    dksb_axis_t       ax, ay;

    assign brush.ready = !full;
    assign push        = brush.valid && !full;

    assign bw = clamp_dim(cfg.brush_width);
    assign bh = clamp_dim(cfg.brush_height);
    assign dw = clamp_dim(cfg.dest_width);
    assign dh = clamp_dim(cfg.dest_height);

    assign col = brush.new_stamp ? '0 : col_reg;
    assign row = brush.new_stamp ? '0 : row_reg;

    assign sum = {2'b0, brush.pixel_red} + {2'b0, brush.pixel_green}
               + {2'b0, brush.pixel_blue};

    assign ax = axis_setup(brush.center_x, bw, dw, col);
    assign ay = axis_setup(brush.center_y, bh, dh, row);

    always_comb
    begin
        item.hit   = (sum < DARK_SUM_LIMIT) && ax.ok && ay.ok;
        item.col   = col;
        item.row   = row;
        item.ofs_x = ax.ofs;
        item.ofs_y = ay.ofs;
        item.lim_x = ax.lim;
        item.lim_y = ay.lim;
    end

    assign col_inc = {1'b0, col} + 13'd1;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (col_inc >= bw)
            begin
                col_next = '0;
                row_next = row + 12'd1;
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### rtl/dksb_queue.sv
// ----------------------------------------------------------------------------
// dksb_queue
// two-entry queue between the classifying front and the write back end
// ----------------------------------------------------------------------------
`include "dark_key_stamp_blit_core_macros.svh"

module dksb_queue
    import dksb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  dksb_item_t wr_item,
    output logic       full,
    input  logic       pop,
    output dksb_item_t head,
    output logic       empty
);

    dksb_item_t entries_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `DKSB_ASSERT_ALWAYS(a_count_bound, count_reg <= 2'd2, "queue count out of range")
    `DKSB_ASSERT_IMPLY(a_no_overflow, push, count_reg != 2'd2, "push into full queue")
    `DKSB_ASSERT_IMPLY(a_no_underflow, pop, count_reg != 2'd0, "pop from empty queue")

endmodule

### rtl/dksb_back.sv
// ----------------------------------------------------------------------------
// dksb_back
// places queued items in the destination and registers the pixel writes
// ----------------------------------------------------------------------------
`include "dark_key_stamp_blit_core_macros.svh"

module dksb_back
    import dksb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dksb_cfg_t  cfg,
    input  logic       empty,
    input  dksb_item_t head,
    output logic       pop,
    dksb_out_if.source dest
);

    logic signed [POS_W-1:0] pos_x, pos_y;
    logic                    place_ok;
    logic                    valid_reg, valid_next;
    logic [CNT_W-1:0]        x_reg, y_reg;
    logic [31:0]             color_reg;

    assign pos_x = $signed({head.ofs_x[OFS_W-1], head.ofs_x})
                 + $signed({4'b0, head.col});
    assign pos_y = $signed({head.ofs_y[OFS_W-1], head.ofs_y})
                 + $signed({4'b0, head.row});

    assign place_ok = head.hit
                    && !pos_x[POS_W-1] && (pos_x[POS_W-2:0] < {2'b0, head.lim_x})
                    && !pos_y[POS_W-1] && (pos_y[POS_W-2:0] < {2'b0, head.lim_y});

    assign pop = !empty && (!valid_reg || dest.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (dest.ready)
        begin
            valid_next = 1'b0;
        end
        if (pop)
        begin
            valid_next = place_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && place_ok)
        begin
            x_reg     <= pos_x[CNT_W-1:0];
            y_reg     <= pos_y[CNT_W-1:0];
            color_reg <= {cfg.stamp_alpha, cfg.stamp_blue, cfg.stamp_green, cfg.stamp_red};
        end
    end

    assign dest.valid       = valid_reg;
    assign dest.write_x     = x_reg;
    assign dest.write_y     = y_reg;
    assign dest.write_color = color_reg;

    `DKSB_ASSERT_IMPLY(a_x_in_dest, valid_reg,
        ({1'b0, x_reg} < clamp_dim(cfg.dest_width)), "write column outside destination")
    `DKSB_ASSERT_IMPLY(a_y_in_dest, valid_reg,
        ({1'b0, y_reg} < clamp_dim(cfg.dest_height)), "write row outside destination")

endmodule

### rtl/dark_key_stamp_blit_core.sv
// an accepted brush pixel is held in a queue entry, then its write sits in the output register on dest
// throughput: one brush pixel per cycle while the queue is not full, with a combinational classify front end
// a two-entry queue lets the front keep accepting while a write waits on dest
// reset: brush column and row to zero, registers to their defaults, queue and
// output empty; no clearing pass
// ----------------------------------------------------------------------------
// dark_key_stamp_blit_core
// color-keyed brush stamp with clipping onto a destination image
// ----------------------------------------------------------------------------
module dark_key_stamp_blit_core
    import dksb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dksb_cfg_if.sink   cfg,
    dksb_in_if.sink    brush,
    dksb_out_if.source dest
);

    dksb_cfg_t  cfg_reg, cfg_next;
    dksb_item_t fr_item, q_head;
    logic       q_push, q_pop, q_full, q_empty;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEST_WIDTH:   cfg_next.dest_width   = cfg.data;
                REG_DEST_HEIGHT:  cfg_next.dest_height  = cfg.data;
                REG_BRUSH_WIDTH:  cfg_next.brush_width  = cfg.data;
                REG_BRUSH_HEIGHT: cfg_next.brush_height = cfg.data;
                REG_STAMP_RED:    cfg_next.stamp_red    = cfg.data[7:0];
                REG_STAMP_GREEN:  cfg_next.stamp_green  = cfg.data[7:0];
                REG_STAMP_BLUE:   cfg_next.stamp_blue   = cfg.data[7:0];
                REG_STAMP_ALPHA:  cfg_next.stamp_alpha  = cfg.data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_width   <= 13'd256;
            cfg_reg.dest_height  <= 13'd256;
            cfg_reg.brush_width  <= 13'd16;
            cfg_reg.brush_height <= 13'd16;
            cfg_reg.stamp_red    <= 8'd0;
            cfg_reg.stamp_green  <= 8'd0;
            cfg_reg.stamp_blue   <= 8'd0;
            cfg_reg.stamp_alpha  <= 8'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dksb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .brush (brush),
        .cfg   (cfg_reg),
        .full  (q_full),
        .push  (q_push),
        .item  (fr_item)
    );

    dksb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (fr_item),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty)
    );

    dksb_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .empty (q_empty),
        .head  (q_head),
        .pop   (q_pop),
        .dest  (dest)
    );

endmodule
